@@ rtl/upd_pkg.sv @@
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and hex helpers for the url percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    // field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;

    // most decoded bytes one source byte can cause
    localparam int JOB_BYTES = 3;
    localparam int JOB_CNT_W = $clog2(JOB_BYTES + 1);

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // capacity after reset
    localparam logic [LEN_W-1:0] CAP_RESET = '1;

    // character codes
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [BYTE_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h66;
    localparam logic [BYTE_W-1:0] UPPER_BIAS = CHAR_UA - 8'd10;
    localparam logic [BYTE_W-1:0] LOWER_BIAS = CHAR_LA - 8'd10;

    // escape tracking between items
    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_PCT  = 2'd1,
        ESC_HEX  = 2'd2
    } esc_phase_t;

    // one decoded item handed from front to back
    typedef struct packed {
        logic [JOB_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [JOB_CNT_W-1:0]             count;
        logic                             fin;
        logic [LEN_W-1:0]                 base_len;
        logic                             trunc;
    } job_t;

    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return ((c >= CHAR_0) && (c <= CHAR_9)) ||
               ((c >= CHAR_UA) && (c <= CHAR_UF)) ||
               ((c >= CHAR_LA) && (c <= CHAR_LF));
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] diff;
        diff = c - CHAR_0;
        if ((c >= CHAR_UA) && (c <= CHAR_UF))
        begin
            diff = c - UPPER_BIAS;
        end
        else if ((c >= CHAR_LA) && (c <= CHAR_LF))
        begin
            diff = c - LOWER_BIAS;
        end
        return diff[3:0];
    endfunction

endpackage

@@ rtl/upd_front.sv @@
// ----------------------------------------------------------------------------
// upd_front
// Accepts source bytes, tracks escapes, applies the capacity limit and queues
// the decoded bytes of each item.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            source_byte,
    input  logic                  final_byte,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data,
    output logic                  push_valid,
    output upd_pkg::job_t         push_job,
    input  logic                  queue_full
);
    import upd_pkg::*;

    esc_phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]       held_reg, held_next;
    logic [LEN_W-1:0]        pc_reg, pc_next;
    logic                    ovf_reg, ovf_next;
    logic [LEN_W-1:0]        cap_reg;

    logic                    accept;
    logic [BYTE_W-1:0]       cand [JOB_BYTES];
    logic [JOB_CNT_W-1:0]    cand_cnt;
    esc_phase_t              phase_mid;
    logic [BYTE_W-1:0]       held_mid;
    logic [LEN_W-1:0]        room;
    logic [JOB_CNT_W-1:0]    allowed;
    logic [LEN_W-1:0]        pc_after;
    logic                    ovf_after;

    assign accept    = in_valid && !queue_full;
    assign in_stall  = queue_full;
    assign cfg_ready = 1'b1;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    // escape decode into up to three candidate bytes
    always_comb
    begin
        logic [JOB_CNT_W-1:0] n;
        logic                 fresh;
        n         = '0;
        fresh     = 1'b0;
        phase_mid = ESC_NONE;
        held_mid  = held_reg;
        for (int i = 0; i < JOB_BYTES; i++)
        begin
            cand[i] = '0;
        end

        unique case (phase_reg)
            ESC_PCT:
            begin
                if (is_hex(source_byte))
                begin
                    held_mid  = source_byte;
                    phase_mid = ESC_HEX;
                end
                else
                begin
                    cand[0] = CHAR_PCT;
                    n       = JOB_CNT_W'(1);
                    fresh   = 1'b1;
                end
            end
            ESC_HEX:
            begin
                if (is_hex(held_reg) && is_hex(source_byte))
                begin
                    cand[0] = {hex_nibble(held_reg), hex_nibble(source_byte)};
                    n       = JOB_CNT_W'(1);
                end
                else
                begin
                    cand[0] = CHAR_PCT;
                    cand[1] = held_reg;
                    n       = JOB_CNT_W'(2);
                    fresh   = 1'b1;
                end
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        // byte decoded on its own
        if (fresh)
        begin
            if (source_byte == CHAR_PLUS)
            begin
                cand[n[1:0]] = CHAR_SPACE;
                n            = n + JOB_CNT_W'(1);
            end
            else if (source_byte == CHAR_PCT)
            begin
                phase_mid = ESC_PCT;
            end
            else
            begin
                cand[n[1:0]] = source_byte;
                n            = n + JOB_CNT_W'(1);
            end
        end

        // escape cut off by end of text
        if (final_byte)
        begin
            if (phase_mid == ESC_PCT)
            begin
                cand[n[1:0]] = CHAR_PCT;
                n            = n + JOB_CNT_W'(1);
            end
            else if (phase_mid == ESC_HEX)
            begin
                cand[0] = CHAR_PCT;
                cand[1] = held_mid;
                n       = JOB_CNT_W'(2);
            end
        end
        cand_cnt = n;
    end

    // capacity limit
    always_comb
    begin
        room      = (pc_reg < cap_reg) ? (cap_reg - pc_reg) : '0;
        allowed   = (room >= LEN_W'(cand_cnt)) ? cand_cnt : room[JOB_CNT_W-1:0];
        pc_after  = pc_reg + LEN_W'(allowed);
        ovf_after = ovf_reg || (allowed != cand_cnt);
    end

    // job to the queue
    always_comb
    begin
        push_valid = accept && ((allowed != '0) || final_byte);
        for (int i = 0; i < JOB_BYTES; i++)
        begin
            push_job.bytes[i] = cand[i];
        end
        push_job.count    = allowed;
        push_job.fin      = final_byte;
        push_job.base_len = pc_reg;
        push_job.trunc    = ovf_after;
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        pc_next    = pc_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (final_byte)
            begin
                phase_next = ESC_NONE;
                held_next  = '0;
                pc_next    = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                phase_next = phase_mid;
                held_next  = held_mid;
                pc_next    = pc_after;
                ovf_next   = ovf_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ESC_NONE;
            held_reg  <= '0;
            pc_reg    <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            pc_reg    <= pc_next;
            ovf_reg   <= ovf_next;
        end
    end

    // a finished text leaves a clean state
    a_text_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_byte) |=> (phase_reg == ESC_NONE && pc_reg == '0 && !ovf_reg))
        else $error("state not cleared after final item");

endmodule

@@ rtl/upd_queue.sv @@
// ----------------------------------------------------------------------------
// upd_queue
// Short first-in first-out queue of decoded items between front and back.
// ----------------------------------------------------------------------------
module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    input  upd_pkg::job_t         push_job,
    output logic                  full,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output upd_pkg::job_t         pop_job
);
    import upd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t              store [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_ready && pop_valid;
    assign pop_job   = store[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // fill level stays in range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill level out of range");

endmodule

@@ rtl/upd_back.sv @@
// ----------------------------------------------------------------------------
// upd_back
// Takes queued items apart into one result per cycle while the output is not
// stalled, and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module upd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  upd_pkg::job_t         pop_job,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            decoded_byte,
    output logic                  byte_present,
    output logic                  run_last,
    output logic                  stream_done,
    output logic [15:0]           decoded_length,
    output logic                  truncated
);
    import upd_pkg::*;

    logic [JOB_CNT_W-1:0]  idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]     byte_reg;
    logic                  present_reg;
    logic                  last_reg;
    logic                  done_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  trunc_reg;

    logic                  advance;
    logic                  take;
    logic                  bare;
    logic                  last;
    logic [BYTE_W-1:0]     pick;

    assign advance   = !out_valid_reg || !out_stall;
    assign take      = advance && pop_valid;
    assign bare      = (pop_job.count == '0);
    assign last      = bare || (idx_reg == pop_job.count - JOB_CNT_W'(1));
    assign pop_ready = take && last;

    // select the byte of this step
    always_comb
    begin
        pick = '0;
        if (!bare)
        begin
            unique case (idx_reg)
                JOB_CNT_W'(0): pick = pop_job.bytes[0];
                JOB_CNT_W'(1): pick = pop_job.bytes[1];
                JOB_CNT_W'(2): pick = pop_job.bytes[2];
                default:       pick = '0;
            endcase
        end
    end

    // step index and output valid
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = pop_valid;
        end
        if (take)
        begin
            idx_next = last ? '0 : idx_reg + JOB_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg    <= pick;
            present_reg <= !bare;
            last_reg    <= last;
            done_reg    <= last && pop_job.fin;
            len_reg     <= bare ? pop_job.base_len
                                : pop_job.base_len + LEN_W'(idx_reg) + LEN_W'(1);
            trunc_reg   <= pop_job.trunc;
        end
    end

    assign out_valid      = out_valid_reg;
    assign decoded_byte   = byte_reg;
    assign byte_present   = present_reg;
    assign run_last       = last_reg;
    assign stream_done    = done_reg;
    assign decoded_length = len_reg;
    assign truncated      = trunc_reg;

    // step index never passes the largest job
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < JOB_CNT_W'(JOB_BYTES))
        else $error("step index out of range");

    // retiring a job shows its last result next
    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ready |=> (out_valid_reg && last_reg))
        else $error("job retired without last result");

endmodule

@@ rtl/url_percent_decoder.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder
// Form-urlencoded percent decoder: one source byte per item in, one decoded
// byte per result out, with capacity limit and end-of-text summary.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  in       | in_valid / in_stall    | source_byte, final_byte
//  out      | out_valid / out_stall  | decoded_byte, byte_present, run_last,
//           |                        | stream_done, decoded_length, truncated
//  cfg      | cfg_valid / cfg_ready  | cfg_data (output_capacity)
//
//  One item is accepted per cycle while the item queue has room.
//  The back end delivers one result per cycle while out_stall is low, and an
//  item with several results holds it until all of them are out; the first
//  result passes the queue store and the output register to the outputs.
//  Reset clears escape state, counters, queue and output valid; capacity = 65535.
//  out_stall holds the output register; in_stall rises only when the queue
//  is full.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  source_byte,
    input  logic        final_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  decoded_byte,
    output logic        byte_present,
    output logic        run_last,
    output logic        stream_done,
    output logic [15:0] decoded_length,
    output logic        truncated
);
    import upd_pkg::*;

    logic  push_valid;
    job_t  push_job;
    logic  queue_full;
    logic  pop_valid;
    logic  pop_ready;
    job_t  pop_job;

    // classify and limit
    upd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .source_byte (source_byte),
        .final_byte  (final_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .push_valid  (push_valid),
        .push_job    (push_job),
        .queue_full  (queue_full)
    );

    // decouple front and back
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // emit results
    upd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_job        (pop_job),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .decoded_byte   (decoded_byte),
        .byte_present   (byte_present),
        .run_last       (run_last),
        .stream_done    (stream_done),
        .decoded_length (decoded_length),
        .truncated      (truncated)
    );

endmodule

@@ tb/url_percent_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder_tb
// Self-checking bench for the percent decoder. A queue of source bytes feeds
// a driver, a predictor tracks escape state, capacity and counts on every
// accepted item, and a monitor compares each result against the oldest
// predicted one. Directed texts come first, then random texts under changing
// capacity and handshake pressure.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb;

    import upd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 64;
    localparam int RUN_LIMIT     = 4000000;
    localparam int PRINT_LIMIT   = 40;
    localparam int PHASE_ITEMS   = 42;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } src_item_t;

    typedef struct {
        logic [7:0]  data;
        logic        present;
        logic        last;
        logic        done;
        logic [15:0] length;
        logic        trunc;
    } decoded_rec_t;

    // block ports
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  source_byte = '0;
    logic        final_byte = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  decoded_byte;
    logic        byte_present;
    logic        run_last;
    logic        stream_done;
    logic [15:0] decoded_length;
    logic        truncated;

    // source bytes waiting for the driver, decoded results waiting for the monitor
    src_item_t    source_q[$];
    decoded_rec_t decoded_q[$];
    src_item_t    next_src;
    logic         in_taken = 1'b0;

    // predictor state
    logic [15:0] capacity = CAP_RESET;
    esc_phase_t  esc_state = ESC_NONE;
    logic [7:0]  held_char = '0;
    logic [15:0] produced = '0;
    logic        overflowed = 1'b0;

    // idling controls
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic hold_req = 1'b0;
    int   hold_count = 0;

    // run statistics
    int error_count = 0;
    int items_queued = 0;
    int items_accepted = 0;
    int texts_accepted = 0;
    int results_checked = 0;
    int bare_markers = 0;
    int trunc_results = 0;
    int input_stalls = 0;
    int cfg_writes = 0;

    url_percent_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .source_byte    (source_byte),
        .final_byte     (final_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .decoded_byte   (decoded_byte),
        .byte_present   (byte_present),
        .run_last       (run_last),
        .stream_done    (stream_done),
        .decoded_length (decoded_length),
        .truncated      (truncated)
    );

    // clock
    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        #RUN_LIMIT;
        $display("%0t: timeout, %0d results still outstanding", $time, decoded_q.size());
        $display("url_percent_decoder_tb: done, errors");
        $finish;
    end

    // hex digit value, -1 for anything else
    function automatic int hex_value(logic [7:0] c);
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            return int'(c) - int'(CHAR_0);
        end
        if (c >= CHAR_UA && c <= CHAR_UF)
        begin
            return int'(c) - int'(CHAR_UA) + 10;
        end
        if (c >= CHAR_LA && c <= CHAR_LF)
        begin
            return int'(c) - int'(CHAR_LA) + 10;
        end
        return -1;
    endfunction

    // predict the results of one accepted source byte
    task automatic decode_source_byte(input logic [7:0] b, input logic fin);
        esc_phase_t   phase;
        logic         redo;
        logic [7:0]   cand[$];
        decoded_rec_t rows[$];
        decoded_rec_t row;
        int           hi;
        int           lo;
        phase = esc_state;
        esc_state = ESC_NONE;
        redo = 1'b1;
        // resolve any pending escape
        if (phase == ESC_PCT)
        begin
            if (hex_value(b) >= 0)
            begin
                held_char = b;
                esc_state = ESC_HEX;
                redo = 1'b0;
            end
            else
            begin
                cand.push_back(CHAR_PCT);
            end
        end
        else if (phase == ESC_HEX)
        begin
            hi = hex_value(held_char);
            lo = hex_value(b);
            if (hi >= 0 && lo >= 0)
            begin
                cand.push_back(8'(hi * 16 + lo));
                redo = 1'b0;
            end
            else
            begin
                cand.push_back(CHAR_PCT);
                cand.push_back(held_char);
            end
        end
        // plain decode of the current byte
        if (redo)
        begin
            if (b == CHAR_PLUS)
            begin
                cand.push_back(CHAR_SPACE);
            end
            else if (b == CHAR_PCT)
            begin
                esc_state = ESC_PCT;
            end
            else
            begin
                cand.push_back(b);
            end
        end
        // escape cut short by end of text
        if (fin)
        begin
            if (esc_state == ESC_PCT)
            begin
                cand.push_back(CHAR_PCT);
            end
            else if (esc_state == ESC_HEX)
            begin
                cand.push_back(CHAR_PCT);
                cand.push_back(held_char);
            end
            esc_state = ESC_NONE;
        end
        // capacity limit
        foreach (cand[i])
        begin
            if (produced < capacity)
            begin
                produced++;
                row.data = cand[i];
                row.present = 1'b1;
                row.length = produced;
                rows.push_back(row);
            end
            else
            begin
                overflowed = 1'b1;
            end
        end
        foreach (rows[i])
        begin
            rows[i].last = (i == rows.size() - 1);
            rows[i].done = (i == rows.size() - 1) && fin;
            rows[i].trunc = overflowed;
            decoded_q.push_back(rows[i]);
        end
        // bare end marker
        if (fin && rows.size() == 0)
        begin
            row.data = '0;
            row.present = 1'b0;
            row.last = 1'b1;
            row.done = 1'b1;
            row.length = produced;
            row.trunc = overflowed;
            decoded_q.push_back(row);
        end
        if (fin)
        begin
            held_char = '0;
            produced = '0;
            overflowed = 1'b0;
        end
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= PRINT_LIMIT)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        end
    endfunction

    // driver: next item at the falling edge once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (source_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_src = source_q.pop_front();
                in_valid <= 1'b1;
                source_byte <= next_src.data;
                final_byte <= next_src.fin;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req && hold_count < HOLD_CYCLES)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge clk)
    begin
        decoded_rec_t want;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && in_stall)
            begin
                input_stalls++;
            end
            if (in_valid && !in_stall)
            begin
                items_accepted++;
                if (final_byte)
                begin
                    texts_accepted++;
                end
                decode_source_byte(source_byte, final_byte);
            end
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (!byte_present)
                begin
                    bare_markers++;
                end
                if (truncated)
                begin
                    trunc_results++;
                end
                if (decoded_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= PRINT_LIMIT)
                    begin
                        $display("%0t: result with none expected, expected nothing, actual 0x%0h",
                                 $time, decoded_byte);
                    end
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("decoded_byte", want.data, decoded_byte);
                    check_field("byte_present", want.present, byte_present);
                    check_field("run_last", want.last, run_last);
                    check_field("stream_done", want.done, stream_done);
                    check_field("decoded_length", want.length, decoded_length);
                    check_field("truncated", want.trunc, truncated);
                end
            end
        end
    end

    task automatic push_item(input logic [7:0] b, input logic fin);
        src_item_t item;
        item.data = b;
        item.fin = fin;
        source_q.push_back(item);
        items_queued++;
    endtask

    task automatic push_text(input string s, input logic ends);
        for (int i = 0; i < s.len(); i++)
        begin
            push_item(s[i], ends && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] random_hex_char();
        int d;
        d = $urandom_range(15);
        if (d < 10)
        begin
            return CHAR_0 + 8'(d);
        end
        if ($urandom_range(1) != 0)
        begin
            return CHAR_UA + 8'(d - 10);
        end
        return CHAR_LA + 8'(d - 10);
    endfunction

    // random text: mostly valid escapes, with plus signs, broken escapes and noise
    task automatic push_random_text(input int max_tokens);
        logic [7:0] text[$];
        int         tokens;
        int         pick;
        tokens = $urandom_range(max_tokens, 1);
        repeat (tokens)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                text.push_back(CHAR_PCT);
                text.push_back(random_hex_char());
                text.push_back(random_hex_char());
            end
            else if (pick < 50)
            begin
                text.push_back(CHAR_PLUS);
            end
            else if (pick < 60)
            begin
                text.push_back(CHAR_PCT);
                if ($urandom_range(1) != 0)
                begin
                    text.push_back(random_hex_char());
                end
                text.push_back(8'($urandom_range(255)));
            end
            else
            begin
                text.push_back(8'($urandom_range(255)));
            end
        end
        foreach (text[i])
        begin
            push_item(text[i], i == text.size() - 1);
        end
    endtask

    task automatic push_random_items(input int count);
        int stop_at;
        stop_at = items_queued + count;
        while (items_queued < stop_at)
        begin
            push_random_text(10);
        end
    endtask

    // wait until everything sent has been decoded and checked
    task automatic wait_idle();
        while (source_q.size() != 0 || in_valid || decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        capacity = value;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed texts under the reset capacity
        push_text("a+b", 1'b1);
        push_text("%4a%F0", 1'b1);
        push_text("%zq%4g", 1'b1);
        push_text("%%4%41", 1'b1);
        push_text("%4", 1'b1);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b1);
        wait_idle();

        // zero capacity drops everything, one byte capacity keeps the first
        write_capacity(16'd0);
        push_text("a%", 1'b1);
        wait_idle();
        write_capacity(16'd1);
        push_text("xy", 1'b1);
        wait_idle();

        // capacity lowered below the count in the middle of a text
        write_capacity(16'hFFFF);
        push_text("ab%", 1'b0);
        wait_idle();
        write_capacity(16'd1);
        push_text("41c", 1'b1);
        wait_idle();

        // long receiver hold-off while the sender keeps going
        write_capacity(16'hFFFF);
        push_random_items(40);
        hold_req = 1'b1;
        wait_idle();

        // random texts across idling modes and capacities
        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 45; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            if (mode % 2 == 0)
            begin
                write_capacity(16'hFFFF);
            end
            else
            begin
                write_capacity(16'($urandom_range(14, 1)));
            end
            push_random_items(PHASE_ITEMS);
            wait_idle();
            write_capacity(16'($urandom_range(20, 2)));
            push_random_items(PHASE_ITEMS);
            wait_idle();
        end

        $display("covered %0d source bytes in %0d texts, %0d results, %0d capacity writes",
                 items_accepted, texts_accepted, results_checked, cfg_writes);
        $display("saw %0d bare end markers, %0d truncated results, %0d input stall cycles",
                 bare_markers, trunc_results, input_stalls);
        if (error_count == 0)
        begin
            $display("url_percent_decoder_tb: done, clean");
        end
        else
        begin
            $display("url_percent_decoder_tb: done, errors");
        end
        $finish;
    end

endmodule
